// ===== rtl/aging_slot_pool_allocator_assert.svh =====
// Assertion macros for the aging slot pool allocator.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef AGING_SLOT_POOL_ALLOCATOR_ASSERT_SVH
`define AGING_SLOT_POOL_ALLOCATOR_ASSERT_SVH

// Implication in the same cycle.
`define ASPA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication into the next cycle.
`define ASPA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/aspa_pkg.sv =====
// Shared constants, codes and types of the aging slot pool allocator.
// No dependencies.
package aspa_pkg;

  localparam int POOL_DEPTH = 64;
  localparam int IDX_W      = $clog2(POOL_DEPTH);
  localparam int CNT_W      = $clog2(POOL_DEPTH + 1);

  localparam int AGE_W  = 24;
  localparam int DT_W   = 16;
  localparam int REQ_W  = 2;
  localparam int OUTC_W = 2;
  localparam int SLOT_W = 6;
  localparam int OCNT_W = 7;

  localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

  // Configuration registers
  localparam int MAXS_W    = 7;
  localparam int FADE_W    = 23;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = FADE_W;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SLOTS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_HOLD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_LENGTH = 2'd2;

  localparam logic [MAXS_W-1:0] MAX_SLOTS_RST   = 7'd64;
  localparam logic [FADE_W-1:0] FADE_HOLD_RST   = 23'd10240;
  localparam logic [FADE_W-1:0] FADE_LENGTH_RST = 23'd2048;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // Outcome codes
  localparam logic [OUTC_W-1:0] OUTC_NONE   = 2'd0;
  localparam logic [OUTC_W-1:0] OUTC_REUSE  = 2'd1;
  localparam logic [OUTC_W-1:0] OUTC_APPEND = 2'd2;
  localparam logic [OUTC_W-1:0] OUTC_EVICT  = 2'd3;

  typedef struct packed {
    logic [CNT_W-1:0] pool_limit; // max_slots clamped to 1..POOL_DEPTH
    logic [AGE_W-1:0] limit_age;  // fade_hold + fade_length
  } cfg_t;

endpackage

// ===== rtl/aspa_age_ram.sv =====
// Slot age store: one write port, one read port, registered read data.
// Depends on aspa_pkg.
module aspa_age_ram
  import aspa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output logic [AGE_W-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  logic [AGE_W-1:0] wr_data_i
);

  logic [AGE_W-1:0] mem_q [POOL_DEPTH];
  logic [AGE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/aspa_cfg_regs.sv =====
// Configuration registers and the derived pool limit and expiry age.
// Depends on aspa_pkg.
module aspa_cfg_regs
  import aspa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  output cfg_t                 cfg_o
);

  logic [MAXS_W-1:0] max_slots_q;
  logic [FADE_W-1:0] fade_hold_q, fade_length_q;
  logic [AGE_W-1:0]  limit_age_q, limit_age_d;
  logic [CNT_W-1:0]  pool_limit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_slots_q   <= MAX_SLOTS_RST;
      fade_hold_q   <= FADE_HOLD_RST;
      fade_length_q <= FADE_LENGTH_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MAX_SLOTS:   max_slots_q   <= cfg_data_i[MAXS_W-1:0];
        CFG_FADE_HOLD:   fade_hold_q   <= cfg_data_i[FADE_W-1:0];
        CFG_FADE_LENGTH: fade_length_q <= cfg_data_i[FADE_W-1:0];
        default: ;
      endcase
    end
  end

  // Registered sum; it follows the fade registers in the cycle after they change.
  assign limit_age_d = {1'b0, fade_hold_q} + {1'b0, fade_length_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_age_q <= AGE_W'({1'b0, FADE_HOLD_RST} + {1'b0, FADE_LENGTH_RST});
    end else begin
      limit_age_q <= limit_age_d;
    end
  end

  always_comb begin
    if (max_slots_q == '0) begin
      pool_limit = CNT_W'(1);
    end else if (32'(max_slots_q) > 32'(POOL_DEPTH)) begin
      pool_limit = CNT_W'(POOL_DEPTH);
    end else begin
      pool_limit = CNT_W'(max_slots_q);
    end
  end

  assign cfg_o.pool_limit = pool_limit;
  assign cfg_o.limit_age  = limit_age_q;

endmodule

// ===== rtl/aging_slot_pool_allocator.sv =====
// Aging slot pool allocator: tick, allocate and clear over a pool of aged slots.
// Tick/allocate: one age read per cycle from the age RAM while the sweep runs over the slots in use;
// the result strobe comes as busy drops at the end of the sweep, and the next transaction is taken
// only once busy is low again, so a new request waits until the last one is finished.
// Clear and unknown requests: strobe the cycle after acceptance, one per cycle; no stall.
// Reset clears live bits and counters at once; ages are left unwritten (no clearing pass).
`include "aging_slot_pool_allocator_assert.svh"

module aging_slot_pool_allocator
  import aspa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request transaction
  input  logic                 start,
  output logic                 busy,
  input  logic [REQ_W-1:0]     req_type_i,
  input  logic [DT_W-1:0]      delta_time_i,
  // result transaction
  output logic                 result_valid_o,
  output logic [OUTC_W-1:0]    outcome_o,
  output logic [SLOT_W-1:0]    slot_index_o,
  output logic [OCNT_W-1:0]    expired_count_o,
  output logic [OCNT_W-1:0]    active_total_o,
  // configuration write transaction
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_TICK  = 3'b010,
    ST_ALLOC = 3'b100
  } state_e;

  cfg_t cfg;

  state_e state_q, state_d;

  // pool state outside the age RAM
  logic [POOL_DEPTH-1:0] live_q, live_d;
  logic [CNT_W-1:0]      slots_in_use_q, slots_in_use_d;
  logic [CNT_W-1:0]      live_count_q, live_count_d;

  // sweep control: read issued at rd_cnt, data for pend_idx arrives in the next cycle
  logic [CNT_W-1:0] rd_cnt_q, rd_cnt_d;
  logic             pend_q, pend_d;
  logic [IDX_W-1:0] pend_idx_q, pend_idx_d;
  logic [DT_W-1:0]  dt_q, dt_d;
  logic [CNT_W-1:0] exp_cnt_q, exp_cnt_d;

  // allocate trackers: lowest dead slot, oldest live slot
  logic             dead_found_q, dead_found_d;
  logic [IDX_W-1:0] dead_idx_q, dead_idx_d;
  logic             best_found_q, best_found_d;
  logic [IDX_W-1:0] best_idx_q, best_idx_d;
  logic [AGE_W-1:0] best_age_q, best_age_d;

  // result registers
  logic              res_valid_q, res_valid_d;
  logic [OUTC_W-1:0] res_outc_q, res_outc_d;
  logic [SLOT_W-1:0] res_slot_q, res_slot_d;
  logic [OCNT_W-1:0] res_exp_q, res_exp_d;
  logic [OCNT_W-1:0] res_act_q, res_act_d;

  // age RAM ports
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [AGE_W-1:0] rd_data, wr_data;

  // datapath
  logic             sweep_last, pend_live, expire_hit, take_best, dead_now;
  logic [AGE_W:0]   age_sum;
  logic [AGE_W-1:0] aged;
  logic [IDX_W-1:0] dead_idx_now, best_idx_now;
  logic [CNT_W-1:0] exp_next, live_next;

  aspa_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  aspa_age_ram u_age_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q != ST_IDLE);

  // ageing with saturation
  assign age_sum    = {1'b0, rd_data} + {{(AGE_W + 1 - DT_W){1'b0}}, dt_q};
  assign aged       = age_sum[AGE_W] ? AGE_MAX : age_sum[AGE_W-1:0];
  assign sweep_last = (rd_cnt_q == slots_in_use_q);
  assign pend_live  = live_q[pend_idx_q];
  assign expire_hit = pend_q && pend_live && (aged >= cfg.limit_age);
  assign exp_next   = exp_cnt_q + CNT_W'(expire_hit);
  assign live_next  = live_count_q - CNT_W'(expire_hit);

  // trackers including the slot whose age arrives this cycle
  assign take_best    = pend_q && pend_live && (!best_found_q || (rd_data > best_age_q));
  assign best_idx_now = take_best ? pend_idx_q : best_idx_q;
  assign dead_now     = dead_found_q || (pend_q && !pend_live);
  assign dead_idx_now = dead_found_q ? dead_idx_q : pend_idx_q;

  always_comb begin
    state_d        = state_q;
    live_d         = live_q;
    slots_in_use_d = slots_in_use_q;
    live_count_d   = live_count_q;
    rd_cnt_d       = rd_cnt_q;
    pend_d         = 1'b0;
    pend_idx_d     = pend_idx_q;
    dt_d           = dt_q;
    exp_cnt_d      = exp_cnt_q;
    dead_found_d   = dead_found_q;
    dead_idx_d     = dead_idx_q;
    best_found_d   = best_found_q;
    best_idx_d     = best_idx_q;
    best_age_d     = best_age_q;
    res_valid_d    = 1'b0;
    res_outc_d     = res_outc_q;
    res_slot_d     = res_slot_q;
    res_exp_d      = res_exp_q;
    res_act_d      = res_act_q;
    rd_en          = 1'b0;
    rd_addr        = rd_cnt_q[IDX_W-1:0];
    wr_en          = 1'b0;
    wr_addr        = pend_idx_q;
    wr_data        = aged;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          dt_d         = delta_time_i;
          rd_cnt_d     = '0;
          exp_cnt_d    = '0;
          dead_found_d = 1'b0;
          best_found_d = 1'b0;
          unique case (req_type_i)
            REQ_TICK:  state_d = ST_TICK;
            REQ_ALLOC: state_d = ST_ALLOC;
            REQ_CLEAR: begin
              live_d       = '0;
              live_count_d = '0;
              res_valid_d  = 1'b1;
              res_outc_d   = OUTC_NONE;
              res_slot_d   = '0;
              res_exp_d    = '0;
              res_act_d    = '0;
            end
            default: begin
              // unknown request: answer with the current live count only
              res_valid_d = 1'b1;
              res_outc_d  = OUTC_NONE;
              res_slot_d  = '0;
              res_exp_d   = '0;
              res_act_d   = OCNT_W'(live_count_q);
            end
          endcase
        end
      end

      ST_TICK: begin
        if (!sweep_last) begin
          rd_en      = 1'b1;
          rd_cnt_d   = rd_cnt_q + CNT_W'(1);
          pend_d     = 1'b1;
          pend_idx_d = rd_cnt_q[IDX_W-1:0];
        end
        // dead slots keep their stored age untouched
        if (pend_q && pend_live) begin
          wr_en = 1'b1;
          if (expire_hit) begin
            live_d[pend_idx_q] = 1'b0;
          end
        end
        exp_cnt_d    = exp_next;
        live_count_d = live_next;
        if (sweep_last) begin
          state_d     = ST_IDLE;
          res_valid_d = 1'b1;
          res_outc_d  = OUTC_NONE;
          res_slot_d  = '0;
          res_exp_d   = OCNT_W'(exp_next);
          res_act_d   = OCNT_W'(live_next);
        end
      end

      ST_ALLOC: begin
        if (!sweep_last) begin
          rd_en      = 1'b1;
          rd_cnt_d   = rd_cnt_q + CNT_W'(1);
          pend_d     = 1'b1;
          pend_idx_d = rd_cnt_q[IDX_W-1:0];
        end
        if (pend_q && !pend_live && !dead_found_q) begin
          dead_found_d = 1'b1;
          dead_idx_d   = pend_idx_q;
        end
        if (take_best) begin
          best_found_d = 1'b1;
          best_idx_d   = pend_idx_q;
          best_age_d   = rd_data;
        end
        if (sweep_last) begin
          state_d     = ST_IDLE;
          wr_en       = 1'b1;
          wr_data     = '0;
          res_valid_d = 1'b1;
          res_exp_d   = '0;
          if (dead_now) begin
            wr_addr              = dead_idx_now;
            live_d[dead_idx_now] = 1'b1;
            live_count_d         = live_count_q + CNT_W'(1);
            res_outc_d           = OUTC_REUSE;
            res_slot_d           = SLOT_W'(dead_idx_now);
            res_act_d            = OCNT_W'(live_count_q + CNT_W'(1));
          end else if (slots_in_use_q < cfg.pool_limit) begin
            wr_addr                               = slots_in_use_q[IDX_W-1:0];
            live_d[slots_in_use_q[IDX_W-1:0]]     = 1'b1;
            slots_in_use_d                        = slots_in_use_q + CNT_W'(1);
            live_count_d                          = live_count_q + CNT_W'(1);
            res_outc_d                            = OUTC_APPEND;
            res_slot_d                            = SLOT_W'(slots_in_use_q[IDX_W-1:0]);
            res_act_d                             = OCNT_W'(live_count_q + CNT_W'(1));
          end else begin
            // every slot in use is live here, so the oldest is already live
            wr_addr    = best_idx_now;
            res_outc_d = OUTC_EVICT;
            res_slot_d = SLOT_W'(best_idx_now);
            res_act_d  = OCNT_W'(live_count_q);
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      live_q         <= '0;
      slots_in_use_q <= '0;
      live_count_q   <= '0;
      rd_cnt_q       <= '0;
      pend_q         <= 1'b0;
      dead_found_q   <= 1'b0;
      best_found_q   <= 1'b0;
      res_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      live_q         <= live_d;
      slots_in_use_q <= slots_in_use_d;
      live_count_q   <= live_count_d;
      rd_cnt_q       <= rd_cnt_d;
      pend_q         <= pend_d;
      dead_found_q   <= dead_found_d;
      best_found_q   <= best_found_d;
      res_valid_q    <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    dt_q       <= dt_d;
    exp_cnt_q  <= exp_cnt_d;
    dead_idx_q <= dead_idx_d;
    best_idx_q <= best_idx_d;
    best_age_q <= best_age_d;
    res_outc_q <= res_outc_d;
    res_slot_q <= res_slot_d;
    res_exp_q  <= res_exp_d;
    res_act_q  <= res_act_d;
  end

  assign result_valid_o  = res_valid_q;
  assign outcome_o       = res_outc_q;
  assign slot_index_o    = res_slot_q;
  assign expired_count_o = res_exp_q;
  assign active_total_o  = res_act_q;

  // live counter tracks the live bits exactly
  `ASPA_ASSERT_IMP(a_live_count, 1'b1, live_count_q == CNT_W'($countones(live_q)), "live count mismatch")
  // pool never grows past its depth
  `ASPA_ASSERT_IMP(a_in_use_max, 1'b1, slots_in_use_q <= CNT_W'(POOL_DEPTH), "pool overgrown")
  // a result is only presented once the sequencer is back to idle
  `ASPA_ASSERT_IMP(a_res_idle, res_valid_q, state_q == ST_IDLE, "result while busy")
  // an accepted transaction either starts a sweep or answers next cycle
  `ASPA_ASSERT_NXT(a_accept, start && !busy, busy || res_valid_q, "request dropped")

endmodule

// ===== test/tb_aging_slot_pool_allocator.sv =====
// Self-checking testbench for aging_slot_pool_allocator: directed table, then random phases.
// Depends on aspa_pkg and the RTL; predicts results with a behavioural model of the pool unless a row gives them.
`timescale 1ns / 100ps

module tb_aging_slot_pool_allocator;
  import aspa_pkg::*;

  // Request code with no meaning to the block; it must answer without touching the pool.
  localparam logic [REQ_W-1:0]     REQ_UNKNOWN = 2'd3;
  // Register index with no register behind it; writes are dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;

  localparam int CYCLE_LIMIT = 800_000;
  localparam int SETTLE      = 4;
  localparam int N_PHASES    = 10;
  localparam int DIR_ROWS    = 30;
  localparam int EXP_DEPTH   = 16;

  typedef struct packed {
    logic [OUTC_W-1:0] outcome;
    logic [SLOT_W-1:0] slot;
    logic [OCNT_W-1:0] expired;
    logic [OCNT_W-1:0] active;
  } slot_result_t;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_DAT_W-1:0] reg_val;
    logic [REQ_W-1:0]     req;
    logic [DT_W-1:0]      dt;
    bit                   typed;   // expected result given in the row
    slot_result_t         want;
  } dir_row_t;

  typedef struct packed {
    logic [MAXS_W-1:0] max_slots;
    logic [FADE_W-1:0] hold;
    logic [FADE_W-1:0] length;
    logic [15:0]       count;
    logic [7:0]        alloc_pct;
    logic [7:0]        clear_pct;
    bit                big_dt;     // ticks mostly of the largest step
  } phase_t;

  localparam slot_result_t NO_RES = '0;

  // Directed part. Reset settings: 64 slots, expiry age 10240 + 2048 = 12288.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_ITEM, CFG_MAX_SLOTS, 23'd0, REQ_TICK, 16'd0, 1'b1,
      '{OUTC_NONE, 6'd0, 7'd0, 7'd0}},                       // tick on an empty pool
    '{ROW_CFG, CFG_MAX_SLOTS, 23'd2, REQ_TICK, 16'd0, 1'b0, NO_RES},
    '{ROW_ITEM, CFG_MAX_SLOTS, 23'd0, REQ_ALLOC, 16'd0, 1'b1,
      '{OUTC_APPEND, 6'd0, 7'd0, 7'd1}},
    '{ROW_ITEM, CFG_MAX_SLOTS, 23'd0, REQ_ALLOC, 16'd0, 1'b1,
      '{OUTC_APPEND, 6'd1, 7'd0, 7'd2}},
    '{ROW_ITEM, CFG_MAX_SLOTS, 23'd0, REQ_ALLOC, 16'd0, 1'b1,
      '{OUTC_EVICT, 6'd0, 7'd0, 7'd2}},                      // full pool, equal ages
    '{ROW_ITEM, CFG_MAX_SLOTS, 23'd0, REQ_TICK, 16'd12287, 1'b1,
      '{OUTC_NONE, 6'd0, 7'd0, 7'd2}},                       // one short of expiry
    '{ROW_ITEM, CFG_MAX_SLOTS, 23'd0, REQ_ALLOC, 16'd0, 1'b1,
      '{OUTC_EVICT, 6'd0, 7'd0, 7'd2}},
    '{ROW_ITEM, CFG_MAX_SLOTS, 23'd0, REQ_TICK, 16'd1, 1'b0, NO_RES},  // slot 1 hits limit
    '{ROW_ITEM, CFG_MAX_SLOTS, 23'd0, REQ_ALLOC, 16'd0, 1'b0, NO_RES}, // reuse dead slot
    '{ROW_ITEM, CFG_MAX_SLOTS, 23'd0, REQ_TICK, 16'hFFFF, 1'b1,
      '{OUTC_NONE, 6'd0, 7'd2, 7'd0}},
    '{ROW_ITEM, CFG_MAX_SLOTS, 23'd0, REQ_UNKNOWN, 16'hFFFF, 1'b1,
      '{OUTC_NONE, 6'd0, 7'd0, 7'd0}},
    '{ROW_ITEM, CFG_MAX_SLOTS, 23'd0, REQ_ALLOC, 16'd0, 1'b0, NO_RES},
    '{ROW_ITEM, CFG_MAX_SLOTS, 23'd0, REQ_CLEAR, 16'd0, 1'b1,
      '{OUTC_NONE, 6'd0, 7'd0, 7'd0}},
    '{ROW_CFG, CFG_FADE_HOLD, 23'd0, REQ_TICK, 16'd0, 1'b0, NO_RES},
    '{ROW_CFG, CFG_FADE_LENGTH, 23'd0, REQ_TICK, 16'd0, 1'b0, NO_RES},
    '{ROW_ITEM, CFG_MAX_SLOTS, 23'd0, REQ_ALLOC, 16'd0, 1'b0, NO_RES},
    '{ROW_ITEM, CFG_MAX_SLOTS, 23'd0, REQ_ALLOC, 16'd0, 1'b0, NO_RES},
    '{ROW_ITEM, CFG_MAX_SLOTS, 23'd0, REQ_TICK, 16'd0, 1'b1,
      '{OUTC_NONE, 6'd0, 7'd2, 7'd0}},                       // zero limit: empty tick kills
    '{ROW_CFG, CFG_MAX_SLOTS, 23'd0, REQ_TICK, 16'd0, 1'b0, NO_RES},   // acts as 1, shrunk
    '{ROW_ITEM, CFG_MAX_SLOTS, 23'd0, REQ_ALLOC, 16'd0, 1'b0, NO_RES},
    '{ROW_ITEM, CFG_MAX_SLOTS, 23'd0, REQ_ALLOC, 16'd0, 1'b0, NO_RES},
    '{ROW_ITEM, CFG_MAX_SLOTS, 23'd0, REQ_ALLOC, 16'd0, 1'b0, NO_RES},
    '{ROW_CFG, CFG_MAX_SLOTS, 23'd127, REQ_TICK, 16'd0, 1'b0, NO_RES}, // clamps to 64
    '{ROW_CFG, CFG_FADE_HOLD, 23'h7FFFFF, REQ_TICK, 16'd0, 1'b0, NO_RES},
    '{ROW_CFG, CFG_FADE_LENGTH, 23'h7FFFFF, REQ_TICK, 16'd0, 1'b0, NO_RES},
    '{ROW_CFG, CFG_SPARE, 23'h2AAAAA, REQ_TICK, 16'd0, 1'b0, NO_RES},
    '{ROW_ITEM, CFG_MAX_SLOTS, 23'd0, REQ_ALLOC, 16'd0, 1'b0, NO_RES},
    '{ROW_ITEM, CFG_MAX_SLOTS, 23'd0, REQ_TICK, 16'hFFFF, 1'b0, NO_RES},
    '{ROW_ITEM, CFG_MAX_SLOTS, 23'd0, REQ_TICK, 16'd0, 1'b0, NO_RES},
    '{ROW_ITEM, CFG_MAX_SLOTS, 23'd0, REQ_CLEAR, 16'd0, 1'b0, NO_RES}
  };

  // Random phases; the last three get settings drawn at run time.
  phase_t phases [N_PHASES] = '{
    '{7'd4,   23'd100,     23'd50,      16'd160, 8'd45, 8'd4, 1'b0},
    '{7'd64,  23'd0,       23'd0,       16'd100, 8'd55, 8'd3, 1'b0},
    '{7'd1,   23'd1000,    23'd0,       16'd120, 8'd45, 8'd4, 1'b0},
    '{7'd127, 23'd3000,    23'd3000,    16'd200, 8'd60, 8'd2, 1'b0},
    '{7'd3,   23'd500,     23'd500,     16'd150, 8'd45, 8'd4, 1'b0},
    '{7'd0,   23'd0,       23'd1,       16'd100, 8'd45, 8'd4, 1'b0},
    '{7'd16,  23'h7FFFFF,  23'h7FFFFF,  16'd300, 8'd8,  8'd0, 1'b1},
    '{7'd0,   23'd0,       23'd0,       16'd160, 8'd45, 8'd4, 1'b0},
    '{7'd0,   23'd0,       23'd0,       16'd160, 8'd45, 8'd4, 1'b0},
    '{7'd0,   23'd0,       23'd0,       16'd160, 8'd45, 8'd4, 1'b0}
  };

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 start        = 1'b0;
  logic                 busy;
  logic [REQ_W-1:0]     req_type_i   = REQ_TICK;
  logic [DT_W-1:0]      delta_time_i = '0;
  logic                 result_valid_o;
  logic [OUTC_W-1:0]    outcome_o;
  logic [SLOT_W-1:0]    slot_index_o;
  logic [OCNT_W-1:0]    expired_count_o;
  logic [OCNT_W-1:0]    active_total_o;
  logic                 cfg_valid_i  = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i  = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i   = '0;

  // Travels with each request so the acceptance monitor knows which expectation to queue
  bit                   row_typed    = 1'b0;
  slot_result_t         row_want     = '0;

  // Predictor copy of the pool and its settings (reset values)
  bit                   pool_live [POOL_DEPTH] = '{default: 1'b0};
  logic [AGE_W-1:0]     pool_age  [POOL_DEPTH];
  int unsigned          slots_used  = 0;
  int unsigned          live_slots  = 0;
  logic [MAXS_W-1:0]    max_slots_q = MAX_SLOTS_RST;
  logic [FADE_W-1:0]    hold_q      = FADE_HOLD_RST;
  logic [FADE_W-1:0]    length_q    = FADE_LENGTH_RST;

  // Expected results in order of acceptance, a small ring
  slot_result_t         exp_fifo [EXP_DEPTH];
  logic [3:0]           exp_wr    = '0;
  logic [3:0]           exp_rd    = '0;
  int unsigned          exp_count = 0;
  int unsigned          errors = 0;
  int unsigned          cycles = 0;
  int unsigned          n_items = 0, n_results = 0;
  int unsigned          n_reuse = 0, n_append = 0, n_evict = 0, n_expired = 0;

  bit                   idle_on    = 1'b1;
  bit                   quiet_tail = 1'b0;
  int unsigned          stretch_left = 40;

  aging_slot_pool_allocator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .req_type_i      (req_type_i),
    .delta_time_i    (delta_time_i),
    .result_valid_o  (result_valid_o),
    .outcome_o       (outcome_o),
    .slot_index_o    (slot_index_o),
    .expired_count_o (expired_count_o),
    .active_total_o  (active_total_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Works out the result of one request and moves the predictor state on.
  function automatic slot_result_t pool_step(input logic [REQ_W-1:0] req,
                                             input logic [DT_W-1:0]  dt);
    slot_result_t     r;
    logic [AGE_W:0]   sum;
    logic [AGE_W-1:0] expiry_age;
    int unsigned      growth_cap;
    int               pick;
    r          = '0;
    expiry_age = {1'b0, hold_q} + {1'b0, length_q};
    growth_cap = (max_slots_q == 0) ? 1 : (max_slots_q > POOL_DEPTH) ? POOL_DEPTH : max_slots_q;
    pick       = -1;
    case (req)
      REQ_TICK: begin
        for (int i = 0; i < slots_used; i++) begin
          if (pool_live[i]) begin
            sum = {1'b0, pool_age[i]} + dt;
            pool_age[i] = sum[AGE_W] ? AGE_MAX : sum[AGE_W-1:0];
            if (pool_age[i] >= expiry_age) begin
              pool_live[i] = 1'b0;
              live_slots--;
              r.expired++;
            end
          end
        end
      end
      REQ_ALLOC: begin
        // lowest dead slot first, then growth, then the oldest live slot
        for (int i = 0; i < slots_used; i++)
          if (!pool_live[i] && pick < 0) pick = i;
        if (pick >= 0) begin
          r.outcome = OUTC_REUSE;
        end else if (slots_used < growth_cap) begin
          pick = slots_used;
          slots_used++;
          r.outcome = OUTC_APPEND;
        end else begin
          for (int i = 0; i < slots_used; i++)
            if (pool_live[i] && (pick < 0 || pool_age[i] > pool_age[pick])) pick = i;
          r.outcome = OUTC_EVICT;
        end
        if (!pool_live[pick]) begin
          pool_live[pick] = 1'b1;
          live_slots++;
        end
        pool_age[pick] = '0;
        r.slot = SLOT_W'(pick);
      end
      REQ_CLEAR: begin
        pool_live  = '{default: 1'b0};
        live_slots = 0;
      end
      default: ;
    endcase
    r.active = OCNT_W'(live_slots);
    return r;
  endfunction

  task automatic compare_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // Acceptance monitor and result checker. Samples at the edge, before the
  // driver's nonblocking updates land, so ordering inside a time step is moot.
  always @(posedge clk_i) begin : scoreboard
    slot_result_t want;
    slot_result_t model_res;
    if (rst_ni) begin
      if (result_valid_o) begin
        n_results++;
        if (exp_count == 0) begin
          $display("%0t: result with nothing expected, actual %0d/%0d/%0d/%0d", $time,
                   outcome_o, slot_index_o, expired_count_o, active_total_o);
          errors++;
        end else begin
          want = exp_fifo[exp_rd];
          exp_rd++;
          exp_count--;
          compare_field("outcome", 8'(want.outcome), 8'(outcome_o));
          compare_field("slot_index", 8'(want.slot), 8'(slot_index_o));
          compare_field("expired_count", 8'(want.expired), 8'(expired_count_o));
          compare_field("active_total", 8'(want.active), 8'(active_total_o));
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_MAX_SLOTS:   max_slots_q = cfg_data_i[MAXS_W-1:0];
          CFG_FADE_HOLD:   hold_q      = cfg_data_i;
          CFG_FADE_LENGTH: length_q    = cfg_data_i;
          default: ;
        endcase
      end
      if (start && !busy) begin
        model_res = pool_step(req_type_i, delta_time_i);
        n_expired += model_res.expired;
        if (req_type_i == REQ_ALLOC) begin
          case (model_res.outcome)
            OUTC_REUSE:  n_reuse++;
            OUTC_APPEND: n_append++;
            default:     n_evict++;
          endcase
        end
        exp_fifo[exp_wr] = row_typed ? row_want : model_res;
        exp_wr++;
        exp_count++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, exp_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // One request transaction; returns at the edge where it is taken.
  task automatic send_item(input logic [REQ_W-1:0] req, input logic [DT_W-1:0] dt,
                           input bit typed, input slot_result_t want);
    start        <= 1'b1;
    req_type_i   <= req;
    delta_time_i <= dt;
    row_typed    <= typed;
    row_want     <= want;
    do @(posedge clk_i); while (busy);
    n_items++;
  endtask

  // Random pause after a transaction; bursts come and go in stretches.
  task automatic idle_gap();
    if (stretch_left == 0) begin
      idle_on      = ($urandom_range(0, 2) != 0);
      stretch_left = $urandom_range(30, 80);
    end
    stretch_left--;
    if (idle_on && !quiet_tail && $urandom_range(0, 99) < 30) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // Wait until every expected result is back, then a little longer.
  task automatic drain();
    do @(posedge clk_i); while (exp_count != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    start <= 1'b0;
    drain();
    if (!quiet_tail && $urandom_range(0, 1)) repeat ($urandom_range(1, 5)) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [DT_W-1:0] pick_step(input phase_t ph);
    int unsigned span;
    int unsigned r;
    r    = $urandom_range(0, 99);
    span = (ph.hold + ph.length) / 3;
    if (span < 1) span = 1;
    if (span > 65535) span = 65535;
    if (ph.big_dt && r < 70) return 16'hFFFF;
    if (r < 6)  return '0;
    if (r < 12) return 16'hFFFF;
    if (r < 25) return DT_W'($urandom);
    return DT_W'($urandom_range(0, span));
  endfunction

  function automatic logic [FADE_W-1:0] pick_fade();
    return FADE_W'($urandom & ((32'd1 << $urandom_range(1, FADE_W)) - 1));
  endfunction

  initial begin
    phase_t           ph;
    logic [REQ_W-1:0] req;
    int unsigned      r;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: boundaries, every request kind, tie on eviction,
    // zero expiry age, shrunk and clamped pool limits.
    for (int k = 0; k < DIR_ROWS; k++) begin
      if (dir_rows[k].kind == ROW_CFG) begin
        write_reg(dir_rows[k].reg_idx, dir_rows[k].reg_val);
      end else begin
        send_item(dir_rows[k].req, dir_rows[k].dt, dir_rows[k].typed, dir_rows[k].want);
        idle_gap();
      end
    end

    // Random phases: the pool state carries over, so a small limit after a
    // large one exercises the shrunk pool.
    for (int p = 0; p < N_PHASES; p++) begin
      ph = phases[p];
      if (p >= N_PHASES - 3) begin
        r            = $urandom_range(0, 99);
        ph.max_slots = (r < 8) ? 7'd0 : (r < 16) ? 7'd127 :
                       MAXS_W'($urandom_range(1, POOL_DEPTH));
        ph.hold      = pick_fade();
        ph.length    = pick_fade();
      end
      quiet_tail = (p == N_PHASES - 1);
      write_reg(CFG_MAX_SLOTS, CFG_DAT_W'(ph.max_slots));
      write_reg(CFG_FADE_HOLD, ph.hold);
      write_reg(CFG_FADE_LENGTH, ph.length);
      for (int n = 0; n < ph.count; n++) begin
        r = $urandom_range(0, 99);
        if (r < ph.alloc_pct)                      req = REQ_ALLOC;
        else if (r < ph.alloc_pct + ph.clear_pct)  req = REQ_CLEAR;
        else if (r < ph.alloc_pct + ph.clear_pct + 3) req = REQ_UNKNOWN;
        else                                       req = REQ_TICK;
        send_item(req, pick_step(ph), 1'b0, NO_RES);
        idle_gap();
      end
    end

    start <= 1'b0;
    drain();
    repeat (POOL_DEPTH + 4) @(posedge clk_i);

    $display("%0d requests, %0d results over %0d cycles; %0d errors", n_items, n_results,
             cycles, errors);
    $display("allocations: %0d reused, %0d appended, %0d evicted; %0d slots expired",
             n_reuse, n_append, n_evict, n_expired);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== aging_slot_pool_allocator.f =====
+incdir+rtl
rtl/aspa_pkg.sv
rtl/aspa_age_ram.sv
rtl/aspa_cfg_regs.sv
rtl/aging_slot_pool_allocator.sv
test/tb_aging_slot_pool_allocator.sv
